/* sv/fahq_pkg.sv */
// ----------------------------------------------------------------------------
// fahq_pkg: shared types and constants for the four-ary min-heap queue
// Action and status codes, widths, and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package fahq_pkg;

  localparam int unsigned ELEM_W     = 24;
  localparam int unsigned PRIO_W     = 64;
  localparam int unsigned OCC_W      = 11;
  localparam int unsigned CAPACITY_D = 1024;

  typedef enum logic [1:0] {
    ACT_ENQ   = 2'd0,
    ACT_DEQ   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  // Datapath commands issued by the controller in one cycle
  typedef struct packed {
    logic load_in;     // capture input beat
    logic rd_parent;   // read parent of hole
    logic up_cmp;      // compare parent, move or place
    logic rd_root;     // read root, start dequeue
    logic rd_last;     // read last entry
    logic ld_last;     // capture last entry as the item to sift down
    logic rd_child;    // issue next child read
    logic child_cmp;   // fold returned child into minimum
    logic dn_step;     // move chosen child up or place
    logic place;       // write held item at hole
  } fahq_cmd_t;

  typedef struct packed {
    logic up_done;     // hole at root or parent not greater
    logic dn_done;     // hole has no children
    logic dn_stop;     // smallest child is not smaller than the held item
    logic last_child;  // current child read is the last of its group
  } fahq_sts_t;

endpackage

`default_nettype wire

/* sv/four_ary_min_heap_queue.sv */
// ----------------------------------------------------------------------------
// four_ary_min_heap_queue: four-ary min-heap priority queue
// Enqueue, dequeue-minimum and clear over a fixed-capacity heap in memory.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. An enqueue is accepted, then for
// each heap level it visits reads the parent, then compares and moves or
// places; a dequeue is accepted and fetches the root and the last entry,
// then per level reads each child in turn and then moves and checks the
// next level, since a single read port fetches up to four children one per
// cycle. Full enqueues, empty dequeues, clears and no-op actions finish as
// they are accepted. The result beat is held in an output register until
// taken, and no new beat is accepted meanwhile.
`default_nettype none

module four_ary_min_heap_queue #(
  parameter int unsigned CAPACITY = fahq_pkg::CAPACITY_D
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [1:0]              in_action,
  input  wire [fahq_pkg::ELEM_W-1:0]       in_element,
  input  wire signed [fahq_pkg::PRIO_W-1:0] in_priority,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [1:0]             out_status,
  output logic [fahq_pkg::ELEM_W-1:0]      out_element,
  output logic signed [fahq_pkg::PRIO_W-1:0] out_priority,
  output logic [fahq_pkg::OCC_W-1:0]       out_occupancy
);
  import fahq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  fahq_cmd_t cmd;
  fahq_sts_t sts;
  logic [CW-1:0] count;
  logic [ELEM_W-1:0]        root_element;
  logic signed [PRIO_W-1:0] root_priority;

  fahq_ctrl #(.CAPACITY(CAPACITY), .CW(CW)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .action(in_action),
    .out_valid, .out_ready, .status(out_status), .out_element, .out_priority,
    .occupancy(out_occupancy), .cmd, .sts, .count, .root_element, .root_priority
  );

  fahq_datapath #(.CAPACITY(CAPACITY), .CW(CW)) u_dp (
    .clk, .rst_n, .cmd, .sts, .count, .in_element, .in_priority,
    .root_element, .root_priority
  );

endmodule

`default_nettype wire

/* sv/fahq_datapath.sv */
// ----------------------------------------------------------------------------
// fahq_datapath: heap storage and sift arithmetic
// Holds the two stores, the hole pointer, the held item and the child minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module fahq_datapath #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire fahq_pkg::fahq_cmd_t     cmd,
  output fahq_pkg::fahq_sts_t          sts,
  input  wire [CW-1:0]                 count,
  input  wire [fahq_pkg::ELEM_W-1:0]   in_element,
  input  wire signed [fahq_pkg::PRIO_W-1:0] in_priority,
  output logic [fahq_pkg::ELEM_W-1:0]  root_element,
  output logic signed [fahq_pkg::PRIO_W-1:0] root_priority
);
  import fahq_pkg::*;

  localparam int unsigned IW = AW + 3;

  logic [ELEM_W-1:0]        elem_mem [CAPACITY];
  logic signed [PRIO_W-1:0] prio_mem [CAPACITY];

  logic [ELEM_W-1:0]        rd_elem_r;
  logic signed [PRIO_W-1:0] rd_prio_r;

  logic [IW-1:0]            hole_r, hole_nxt;
  logic [ELEM_W-1:0]        hold_elem_r;
  logic signed [PRIO_W-1:0] hold_prio_r;
  logic [IW-1:0]            kid_r;      // next child index to read
  logic [IW-1:0]            rdaddr_r;   // index of data in rd_*_r
  logic [IW-1:0]            pick_r;
  logic [ELEM_W-1:0]        low_elem_r;
  logic signed [PRIO_W-1:0] low_prio_r;
  logic                     have_low_r;

  logic [IW-1:0] rd_idx;
  logic          rd_en;
  logic          we;
  logic [IW-1:0] wr_idx;
  logic [ELEM_W-1:0]        wr_elem;
  logic signed [PRIO_W-1:0] wr_prio;
  logic [IW-1:0] cnt_ext;
  logic [IW-1:0] first_c;
  logic [IW-1:0] end_c;
  logic          take;

  assign cnt_ext = IW'(count);
  assign first_c = {hole_r[IW-3:0], 2'b00} + IW'(1);
  assign end_c   = ((first_c + IW'(4)) > cnt_ext) ? cnt_ext : (first_c + IW'(4));
  assign take    = !have_low_r || (rd_prio_r < low_prio_r);

  always_comb begin
    rd_en = 1'b0;
    rd_idx = '0;
    if (cmd.rd_parent) begin
      rd_en = 1'b1; rd_idx = (hole_r - IW'(1)) >> 2;
    end else if (cmd.rd_root) begin
      rd_en = 1'b1; rd_idx = '0;
    end else if (cmd.rd_last) begin
      rd_en = 1'b1; rd_idx = cnt_ext;
    end else if (cmd.rd_child) begin
      rd_en = 1'b1; rd_idx = kid_r;
    end
  end

  always_comb begin
    we = 1'b0;
    wr_idx = hole_r;
    wr_elem = hold_elem_r;
    wr_prio = hold_prio_r;
    hole_nxt = hole_r;
    if (cmd.up_cmp) begin
      we = 1'b1;
      if (rd_prio_r > hold_prio_r) begin
        wr_elem = rd_elem_r; wr_prio = rd_prio_r; hole_nxt = rdaddr_r;
      end
    end else if (cmd.dn_step) begin
      we = 1'b1;
      if (have_low_r && low_prio_r < hold_prio_r) begin
        wr_elem = low_elem_r; wr_prio = low_prio_r; hole_nxt = pick_r;
      end
    end else if (cmd.place) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      elem_mem[wr_idx[AW-1:0]] <= wr_elem;
      prio_mem[wr_idx[AW-1:0]] <= wr_prio;
    end
    if (rd_en) begin
      rd_elem_r <= elem_mem[rd_idx[AW-1:0]];
      rd_prio_r <= prio_mem[rd_idx[AW-1:0]];
      rdaddr_r  <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_r     <= '0;
      kid_r      <= '0;
      have_low_r <= 1'b0;
    end else begin
      hole_r <= hole_nxt;
      if (cmd.load_in) begin
        hole_r <= cnt_ext;
      end
      if (cmd.rd_last) begin
        hole_r <= '0;
      end
      if (cmd.rd_child) begin
        kid_r <= kid_r + IW'(1);
      end
      if (cmd.child_cmp && take) begin
        have_low_r <= 1'b1;
        pick_r     <= rdaddr_r;
        low_elem_r <= rd_elem_r;
        low_prio_r <= rd_prio_r;
      end
      // arm child scan for the new hole
      if (cmd.dn_step || cmd.rd_last) begin
        have_low_r <= 1'b0;
        kid_r      <= {hole_nxt[IW-3:0], 2'b00} + IW'(1);
      end
      if (cmd.rd_last) begin
        kid_r <= IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      hold_elem_r <= in_element;
      hold_prio_r <= in_priority;
    end else if (cmd.ld_last) begin
      hold_elem_r <= rd_elem_r;
      hold_prio_r <= rd_prio_r;
    end
  end

  assign root_element  = rd_elem_r;
  assign root_priority = rd_prio_r;

  assign sts.up_done    = (hole_r == '0) || (rd_prio_r <= hold_prio_r);
  assign sts.dn_done    = (first_c >= cnt_ext);
  assign sts.dn_stop    = !(have_low_r && (low_prio_r < hold_prio_r));
  assign sts.last_child = (kid_r >= end_c);

endmodule

`default_nettype wire

/* sv/fahq_ctrl.sv */
// ----------------------------------------------------------------------------
// fahq_ctrl: operation sequencer for the heap queue
// Decodes the action, owns the entry count and steps the sift loops.
// ----------------------------------------------------------------------------
`default_nettype none

module fahq_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire [1:0]                     action,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [1:0]                    status,
  output logic [fahq_pkg::ELEM_W-1:0]   out_element,
  output logic signed [fahq_pkg::PRIO_W-1:0] out_priority,
  output logic [fahq_pkg::OCC_W-1:0]    occupancy,
  output fahq_pkg::fahq_cmd_t           cmd,
  input  wire fahq_pkg::fahq_sts_t      sts,
  output logic [CW-1:0]                 count,
  input  wire [fahq_pkg::ELEM_W-1:0]    root_element,
  input  wire signed [fahq_pkg::PRIO_W-1:0] root_priority
);
  import fahq_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_UPRD  = 9'b000000010,
    S_UPCMP = 9'b000000100,
    S_ROOT  = 9'b000001000,
    S_LAST  = 9'b000010000,
    S_LWAIT = 9'b000100000,
    S_DNRD  = 9'b001000000,
    S_DNCMP = 9'b010000000,
    S_DNSTP = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic          ovalid_r;
  status_t       status_r;
  logic [ELEM_W-1:0]        oelem_r;
  logic signed [PRIO_W-1:0] oprio_r;
  logic [CW-1:0]            cnt_m1;
  logic          accept;
  logic          finish;

  assign in_ready = (state_r == S_IDLE) && !ovalid_r;
  assign accept   = in_valid && in_ready;
  assign count    = count_r;
  assign cnt_m1   = count_r - CW'(1);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_ENQ: begin
              if (count_r >= CW'(CAPACITY)) begin
                finish = 1'b1;
              end else begin
                cmd.load_in = 1'b1;
                state_nxt = S_UPRD;
              end
            end
            ACT_DEQ: begin
              if (count_r == '0) begin
                finish = 1'b1;
              end else begin
                cmd.rd_root = 1'b1;
                state_nxt = S_ROOT;
              end
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_UPRD: begin
        cmd.rd_parent = 1'b1;
        state_nxt = S_UPCMP;
      end
      S_UPCMP: begin
        if (sts.up_done) begin
          cmd.place = 1'b1;
          finish = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.up_cmp = 1'b1;
          state_nxt = S_UPRD;
        end
      end
      S_ROOT: begin
        if (count_r == '0) begin
          finish = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_last = 1'b1;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        cmd.ld_last = 1'b1;
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        if (sts.dn_done) begin
          cmd.place = 1'b1;
          finish = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_child = 1'b1;
          state_nxt = S_DNRD;
        end
      end
      S_DNRD: begin
        cmd.child_cmp = 1'b1;
        if (sts.last_child) begin
          state_nxt = S_DNSTP;
        end else begin
          cmd.rd_child = 1'b1;
        end
      end
      S_DNSTP: begin
        // stop here when the smallest child is not smaller
        if (sts.dn_stop) begin
          cmd.place = 1'b1;
          finish = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.dn_step = 1'b1;
          state_nxt = S_DNCMP;
        end
      end
      S_DNCMP: begin
        if (sts.dn_done) begin
          cmd.place = 1'b1;
          finish = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.rd_child = 1'b1;
          state_nxt = S_DNRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) begin
        ovalid_r <= 1'b0;
      end
      if (finish) begin
        ovalid_r <= 1'b1;
      end
      if (accept && action == ACT_CLEAR) begin
        count_r <= '0;
      end
      if (cmd.load_in) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.rd_root) begin
        count_r <= cnt_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      oelem_r  <= '0;
      oprio_r  <= '0;
      status_r <= ST_OK;
      if (action == ACT_ENQ && count_r >= CW'(CAPACITY)) begin
        status_r <= ST_FULL;
      end
      if (action == ACT_DEQ && count_r == '0) begin
        status_r <= ST_EMPTY;
      end
    end
    if (state_r == S_ROOT) begin
      oelem_r <= root_element;
      oprio_r <= root_priority;
    end
  end

  assign out_valid    = ovalid_r;
  assign status       = status_r;
  assign out_element  = oelem_r;
  assign out_priority = oprio_r;
  assign occupancy    = OCC_W'(count_r);

endmodule

`default_nettype wire

/* sv/fahq_checker.sv */
// ----------------------------------------------------------------------------
// fahq_checker: port-level checks for the heap queue
// Watches handshakes and result codes at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module fahq_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire [1:0]  out_status,
  input wire [23:0] out_element,
  input wire [10:0] out_occupancy
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result beat dropped while stalled");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("new beat taken while result pending");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 2'd1 |-> out_element == '0 && out_occupancy == '0)
    else $error("empty dequeue returned data");

  a_full_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == 2'd2 |-> out_occupancy != '0)
    else $error("full reported on empty queue");

endmodule

bind four_ary_min_heap_queue fahq_checker u_fahq_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_status, .out_element, .out_occupancy
);

`default_nettype wire
